// ===== design/lpht_pkg.sv =====
// Package: types and constants for the linear probing hash table.
`default_nettype none
package lpht_pkg;
  localparam int unsigned TableDepth = 256;
  localparam int unsigned KeyWidth   = 32;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CapW = $clog2(TableDepth + 1);

  localparam logic [2:0] CmdInsert = 3'd0;
  localparam logic [2:0] CmdLookup = 3'd1;
  localparam logic [2:0] CmdRemove = 3'd2;
  localparam logic [2:0] CmdDisp   = 3'd3;
  localparam logic [2:0] CmdRehash = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StBadHome  = 2'd3;

  localparam logic [0:0] RegCapacity = 1'd0;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [KeyWidth-1:0] key;
    logic [7:0]          home_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [7:0]          slot_index;
    logic [KeyWidth-1:0] found_key;
    logic [15:0]         displacement_total;
  } out_item_t;
endpackage
`default_nettype wire

// ===== design/linear_probe_hash_table.sv =====
// Top level: linear probing hash table with its key and home memories.
//
// Channel  Direction  Handshake        Payload
// in       input      in_valid/stall   lpht_pkg::in_item_t
// out      output     out_valid/stall  lpht_pkg::out_item_t
// cfg      input      APB write/read   capacity_in_use
//
// One item at a time. Insert, lookup and remove probe slots in turn from the home
// slot until they finish or have visited every slot within capacity; a bad home
// or an unknown command is answered from the idle state without a probe.
// Displacement visits every slot within capacity, and rehash visits each slot and
// probes from the home of each displaced entry. Each slot visited is read through
// the single memory read port, address first and registered data after.
// Valid bits sit in flip-flops that reset clears at once; no clearing pass.
// A result waits in the output register; the next transaction is accepted no
// earlier than the edge at which that result leaves.
`default_nettype none
module linear_probe_hash_table (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire lpht_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lpht_pkg::out_item_t       out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [0:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import lpht_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_CHK   = 7'b0000100,
    S_RHRD  = 7'b0001000,
    S_RHCHK = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_RHI   = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Memories and valid bits
  logic [KeyWidth-1:0] key_mem [TableDepth];
  logic [7:0]          home_mem [TableDepth];
  logic [TableDepth-1:0] valid;
  logic [TableDepth-1:0] valid_next;
  logic [KeyWidth-1:0] rd_key;
  logic [7:0]          rd_home;

  logic [CapW-1:0] capacity;
  logic [8:0]      entry_count;
  logic [IdxW-1:0] cap_m1;
  in_item_t        cur;
  logic [IdxW-1:0] ptr, cnt;   // probe pointer and probe count
  logic [IdxW-1:0] rh_i;       // rehash outer slot
  logic [KeyWidth-1:0] mv_key;
  logic [7:0]      mv_home;
  logic [IdxW-1:0] mv_dist;
  logic [15:0]     sum;
  logic            out_full;

  logic [CapW-1:0] cap_eff;
  always_comb begin
    cap_eff = capacity;
    if (capacity == '0) cap_eff = CapW'(1);
    if (capacity > CapW'(TableDepth)) cap_eff = CapW'(TableDepth);
  end
  assign cap_m1 = IdxW'(cap_eff - CapW'(1));

  // APB configuration
  assign pready = 1'b1;
  assign prdata = 32'(capacity);

  // Memory port: one read address, one write
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [KeyWidth-1:0] wr_key;
  logic [7:0]      wr_home;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr]  <= wr_key;
      home_mem[wr_addr] <= wr_home;
    end
    rd_key  <= key_mem[rd_addr];
    rd_home <= home_mem[rd_addr];
  end

  function automatic logic [IdxW-1:0] wrap_inc(logic [IdxW-1:0] v, logic [IdxW-1:0] last);
    wrap_inc = (v == last) ? '0 : v + IdxW'(1);
  endfunction

  // Distance of an entry at slot s with home h; zero for a stale home
  logic [IdxW-1:0] slot_dist;
  logic            home_ok;
  always_comb begin
    home_ok = CapW'(rd_home) < cap_eff;
    if (!home_ok) slot_dist = '0;
    else if (ptr >= IdxW'(rd_home)) slot_dist = ptr - IdxW'(rd_home);
    else slot_dist = IdxW'(CapW'(ptr) + cap_eff - CapW'(rd_home));
  end

  wire out_acc = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE) || (out_full && !out_acc);
  wire in_acc  = in_valid && !in_stall;
  assign out_valid = out_full;

  out_item_t res;
  logic      res_set;
  wire last_probe = (cnt == cap_m1);

  always_comb begin
    state_next = state;
    rd_addr = ptr;
    wr_en = 1'b0;
    wr_addr = ptr;
    wr_key = cur.key;
    wr_home = cur.home_index;
    res = '0;
    res_set = 1'b0;
    case (state)
      S_IDLE: begin
        rd_addr = IdxW'(in_data.home_index);
        if (in_acc) begin
          if (in_data.cmd <= CmdRemove && CapW'(in_data.home_index) >= cap_eff) begin
            res.status = StBadHome;
            res_set = 1'b1;
          end else if (in_data.cmd inside {CmdInsert, CmdLookup, CmdRemove, CmdDisp,
                                           CmdRehash}) begin
            state_next = (in_data.cmd == CmdRehash) ? S_RHI : S_RD;
          end else begin
            res_set = 1'b1;
          end
        end
      end
      S_RD:  state_next = S_CHK;
      S_CHK: begin
        case (cur.cmd)
          CmdInsert: begin
            if (!valid[ptr]) begin
              wr_en = 1'b1;
              res.slot_index = 8'(ptr);
              res_set = 1'b1;
              state_next = S_IDLE;
            end else if (last_probe) begin
              res.status = StFull;
              res_set = 1'b1;
              state_next = S_IDLE;
            end else state_next = S_RD;
          end
          CmdLookup, CmdRemove: begin
            if (valid[ptr] && rd_key == cur.key) begin
              res.slot_index = 8'(ptr);
              if (cur.cmd == CmdLookup) res.found_key = rd_key;
              res_set = 1'b1;
              state_next = S_IDLE;
            end else if (last_probe) begin
              res.status = StNotFound;
              res_set = 1'b1;
              state_next = S_IDLE;
            end else state_next = S_RD;
          end
          default: begin
            if (last_probe) begin
              res.displacement_total = sum + (valid[ptr] ? 16'(slot_dist) : 16'd0);
              res_set = 1'b1;
              state_next = S_IDLE;
            end else state_next = S_RD;
          end
        endcase
      end
      // Rehash: read outer slot, then scan from its home
      S_RHI: begin
        rd_addr = rh_i;
        state_next = S_DONE;
      end
      S_DONE: begin
        // rd_* now hold slot rh_i; ptr equals rh_i here
        if (valid[rh_i] && slot_dist != '0) begin
          rd_addr = IdxW'(rd_home);
          state_next = S_RHRD;
        end else if (rh_i == cap_m1) begin
          res_set = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_addr = rh_i + IdxW'(1);
          state_next = S_RHI;
        end
      end
      S_RHRD: state_next = S_RHCHK;
      S_RHCHK: begin
        wr_key = mv_key;
        wr_home = mv_home;
        if (!valid[ptr] || cnt == mv_dist - IdxW'(1)) begin
          wr_en = !valid[ptr];
          if (rh_i == cap_m1) begin
            res_set = 1'b1;
            state_next = S_IDLE;
          end else state_next = S_RHI;
        end else state_next = S_RHRD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Valid bit updates
  always_comb begin
    valid_next = valid;
    if (state == S_CHK && cur.cmd == CmdInsert && !valid[ptr]) valid_next[ptr] = 1'b1;
    if (state == S_CHK && cur.cmd == CmdRemove && valid[ptr] && rd_key == cur.key)
      valid_next[ptr] = 1'b0;
    if (state == S_RHCHK && !valid[ptr]) begin
      valid_next[ptr]  = 1'b1;
      valid_next[rh_i] = 1'b0;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      entry_count <= '0;
      capacity <= CapW'(TableDepth);
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      if (psel && penable && pwrite && paddr == RegCapacity) capacity <= CapW'(pwdata);
      if (res_set) out_full <= 1'b1;
      else if (out_acc) out_full <= 1'b0;
      // entry count updates
      if (state == S_CHK && cur.cmd == CmdInsert && !valid[ptr])
        entry_count <= entry_count + 9'd1;
      if (state == S_CHK && cur.cmd == CmdRemove && valid[ptr] && rd_key == cur.key)
        entry_count <= entry_count - 9'd1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (res_set) out_data <= res;
    case (state)
      S_IDLE: begin
        cur <= in_data;
        ptr <= (in_data.cmd == CmdDisp) ? '0 : IdxW'(in_data.home_index);
        cnt <= '0;
        sum <= '0;
        rh_i <= '0;
      end
      S_CHK: begin
        if (valid[ptr]) sum <= sum + 16'(slot_dist);
        ptr <= wrap_inc(ptr, cap_m1);
        cnt <= cnt + IdxW'(1);
      end
      S_RHI: ptr <= rh_i;
      S_DONE: begin
        mv_key  <= rd_key;
        mv_home <= rd_home;
        mv_dist <= slot_dist;
        cnt <= '0;
        if (valid[rh_i] && slot_dist != '0) ptr <= IdxW'(rd_home);
        else rh_i <= rh_i + IdxW'(1);
      end
      S_RHCHK: begin
        ptr <= wrap_inc(ptr, cap_m1);
        cnt <= cnt + IdxW'(1);
        if (!valid[ptr] || cnt == mv_dist - IdxW'(1)) rh_i <= rh_i + IdxW'(1);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the linear probing hash table: directed, random and back-pressure tests.
`timescale 1ns / 100ps
module tb_top;
  import lpht_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [0:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the table
  logic [31:0] shadow_key [TableDepth];
  logic [7:0]  shadow_home [TableDepth];
  bit          shadow_valid [TableDepth];
  logic [8:0]  shadow_cap;

  out_item_t   pending_results[$];
  int          error_count;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int          rx_hold_cycles;

  linear_probe_hash_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit
  initial begin
    #50000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int unsigned active_cap();
    if (shadow_cap == 0) return 1;
    if (shadow_cap > TableDepth) return TableDepth;
    return 32'(shadow_cap);
  endfunction

  // Distance from home in probe order; stale homes count as zero
  function automatic int unsigned probe_distance(int unsigned slot, int unsigned home,
                                                 int unsigned cap);
    if (home >= cap) return 0;
    if (slot >= home) return slot - home;
    return slot + cap - home;
  endfunction

  // Apply one transaction to the shadow table and return its result
  function automatic out_item_t apply_to_table(in_item_t it);
    out_item_t   r;
    int unsigned c, i, j, n, d, sum;
    bit          hit;
    r = '0;
    c = active_cap();
    hit = 1'b0;
    sum = 0;
    if (it.cmd <= CmdRemove && it.home_index >= c) begin
      r.status = StBadHome;
    end else begin
      case (it.cmd)
        CmdInsert: begin
          i = 32'(it.home_index);
          for (n = 0; n < c; n++) begin
            if (!shadow_valid[i]) begin
              shadow_key[i] = it.key;
              shadow_home[i] = it.home_index;
              shadow_valid[i] = 1'b1;
              r.slot_index = i[7:0];
              hit = 1'b1;
              break;
            end
            i++;
            if (i == c) i = 0;
          end
          if (!hit) r.status = StFull;
        end
        CmdLookup, CmdRemove: begin
          i = 32'(it.home_index);
          for (n = 0; n < c; n++) begin
            if (shadow_valid[i] && shadow_key[i] == it.key) begin
              hit = 1'b1;
              break;
            end
            i++;
            if (i == c) i = 0;
          end
          if (!hit) begin
            r.status = StNotFound;
          end else begin
            r.slot_index = i[7:0];
            if (it.cmd == CmdLookup) r.found_key = shadow_key[i];
            else shadow_valid[i] = 1'b0;
          end
        end
        CmdDisp: begin
          for (i = 0; i < c; i++)
            if (shadow_valid[i]) sum += probe_distance(i, 32'(shadow_home[i]), c);
          r.displacement_total = sum[15:0];
        end
        CmdRehash: begin
          for (i = 0; i < c; i++) begin
            if (!shadow_valid[i]) continue;
            d = probe_distance(i, 32'(shadow_home[i]), c);
            j = 32'(shadow_home[i]);
            for (n = 0; n < d; n++) begin
              if (j == c) j = 0;
              if (!shadow_valid[j]) begin
                shadow_key[j] = shadow_key[i];
                shadow_home[j] = shadow_home[i];
                shadow_valid[j] = 1'b1;
                shadow_valid[i] = 1'b0;
                break;
              end
              j++;
            end
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Offer one transaction and hold it until accepted
  task automatic send_item(logic [2:0] cmd, logic [31:0] key, logic [7:0] home);
    in_item_t    it;
    int unsigned gap;
    it.cmd = cmd;
    it.key = key;
    it.home_index = home;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_to_table(it));
  endtask

  // Drop valid and wait for every result
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [31:0] value);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= RegCapacity;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_cap = value[8:0];
  endtask

  // Check each result against the oldest expectation
  initial begin
    int unsigned stall_left;
    out_item_t   want;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 64'(out_data), 64'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 64'(out_data.status), 64'(want.status));
          if (out_data.slot_index !== want.slot_index)
            report_mismatch("slot_index", 64'(out_data.slot_index), 64'(want.slot_index));
          if (out_data.found_key !== want.found_key)
            report_mismatch("found_key", 64'(out_data.found_key), 64'(want.found_key));
          if (out_data.displacement_total !== want.displacement_total)
            report_mismatch("displacement_total", 64'(out_data.displacement_total),
                            64'(want.displacement_total));
        end
        stall_left = rx_idle_on ? $urandom_range(0, 19) : 0;
      end
      if (rx_hold_cycles > 0) rx_hold_cycles--;
      if (stall_left > 0) stall_left--;
      out_stall <= (rx_hold_cycles > 0) || (stall_left > 0);
    end
  end

  task automatic test_directed();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // Key and home extremes at full capacity
    send_item(CmdInsert, 32'h0, 8'd0);
    send_item(CmdInsert, 32'hFFFF_FFFF, 8'd255);
    send_item(CmdInsert, 32'hFFFF_FFFF, 8'd255);
    send_item(CmdLookup, 32'hFFFF_FFFF, 8'd255);
    send_item(CmdLookup, 32'h0, 8'd200);
    send_item(CmdRemove, 32'h1234_5678, 8'd7);
    send_item(CmdDisp, 32'h0, 8'd0);
    send_item(CmdRehash, 32'h0, 8'd0);
    send_item(CmdRemove, 32'h0, 8'd0);
    send_item(3'd5, 32'hA5A5_A5A5, 8'd3);
    send_item(3'd7, 32'h5A5A_5A5A, 8'd255);
    // Small window: bad home, full table, wrap, stale entries beyond capacity
    write_capacity(32'd4);
    send_item(CmdInsert, 32'd11, 8'd4);
    send_item(CmdInsert, 32'd12, 8'd3);
    send_item(CmdInsert, 32'd13, 8'd3);
    send_item(CmdInsert, 32'd14, 8'd3);
    send_item(CmdInsert, 32'd15, 8'd2);
    send_item(CmdInsert, 32'd16, 8'd2);
    send_item(CmdLookup, 32'd14, 8'd3);
    send_item(CmdRemove, 32'd13, 8'd3);
    send_item(CmdDisp, 32'd0, 8'd0);
    send_item(CmdRehash, 32'd0, 8'd0);
    send_item(CmdDisp, 32'd0, 8'd0);
    // Capacity zero acts as one, above the depth as the depth
    write_capacity(32'd0);
    send_item(CmdLookup, 32'h0, 8'd0);
    send_item(CmdInsert, 32'h77, 8'd1);
    write_capacity(32'h1FF);
    send_item(CmdDisp, 32'd0, 8'd0);
    send_item(CmdRehash, 32'd0, 8'd0);
  endtask

  task automatic test_random();
    int unsigned caps[10] = '{2, 7, 16, 1, 31, 64, 256, 5, 300, 12};
    logic [31:0] pool[8];
    int unsigned p, k, c, pick;
    logic [2:0]  cmd;
    logic [31:0] key;
    logic [7:0]  home;
    for (p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      c = active_cap();
      tx_idle_on = p[0];
      rx_idle_on = (p % 3) != 0;
      foreach (pool[q]) pool[q] = $urandom;
      for (k = 0; k < 145; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 42) cmd = CmdInsert;
        else if (pick < 68) cmd = CmdLookup;
        else if (pick < 90) cmd = CmdRemove;
        else if (pick < 95) cmd = CmdDisp;
        else if (pick < 99) cmd = (c <= 64) ? CmdRehash : CmdLookup;
        else cmd = 3'($urandom_range(5, 7));
        key = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 7)];
        home = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, c - 1));
        send_item(cmd, key, home);
      end
    end
  endtask

  // Hold the output off while input keeps arriving
  task automatic test_back_pressure();
    int unsigned k;
    write_capacity(32'd16);
    tx_idle_on = 1'b0;
    rx_hold_cycles = 400;
    for (k = 0; k < 12; k++)
      send_item(k[0] ? CmdLookup : CmdInsert, $urandom, 8'($urandom_range(0, 15)));
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    rx_hold_cycles = 0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    shadow_cap = 9'd256;
    foreach (shadow_valid[k]) shadow_valid[k] = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_back_pressure();
    drain();
    repeat (20) @(posedge clk);
    while (pending_results.size() != 0) begin
      void'(pending_results.pop_front());
      report_mismatch("missing result", 64'd0, 64'd1);
    end
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== linear_probe_hash_table.f =====
design/lpht_pkg.sv
design/linear_probe_hash_table.sv
tb/tb_top.sv
